// ===== hw/rtl/dcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited command deframer package
// Shared constants and types for the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int MAX_COMMAND = 50;
    localparam int LEN_W       = $clog2(MAX_COMMAND + 1);
    localparam int ADDR_W      = (MAX_COMMAND > 1) ? $clog2(MAX_COMMAND) : 1;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [7:0] START_RESET = 8'h21;
    localparam logic [7:0] END_RESET   = 8'h23;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam logic [CFG_ADDR_W-1:0] REG_START_CHAR = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_END_CHAR   = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_EOL  = 2'd2
    } t_kind;

    typedef struct packed {
        logic             is_end;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic              frame_done;
        logic [ADDR_W-1:0] rd_addr;
    } t_back_req;

endpackage

// ===== hw/rtl/dcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts received bytes, tracks the capture state, stores command bytes and
// issues echo and frame-end commands to the queue.
// ----------------------------------------------------------------------------
module dcd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dcd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_in_byte,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output dcd_pkg::t_cmd                     o_q_cmd,
    input  dcd_pkg::t_back_req                i_req,
    output logic [7:0]                        o_rd_data
);
    import dcd_pkg::*;

    logic [7:0]       r_start_char;
    logic [7:0]       r_end_char;
    logic             r_capturing;
    logic             n_capturing;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_busy;
    logic             n_busy;
    logic [7:0]       r_store [MAX_COMMAND];
    logic [7:0]       r_rd_data;
    logic             accept;
    logic             store_we;

    assign full   = i_q_full | r_busy;
    assign accept = push & ~full;

    always_comb begin
        n_capturing = r_capturing;
        n_len       = r_len;
        n_busy      = r_busy;
        store_we    = 1'b0;
        o_q_push    = 1'b0;
        o_q_cmd     = '{is_end: 1'b0, data: i_in_byte, len: r_len};
        if (i_req.frame_done) begin
            n_busy = 1'b0;
        end
        if (accept && (i_in_byte != 8'd0)) begin
            o_q_push = 1'b1;
            if (!r_capturing) begin
                if (i_in_byte == r_start_char) begin
                    n_capturing = 1'b1;
                    n_len       = '0;
                end
            end else if (i_in_byte == r_start_char) begin
                n_len = '0;
            end else if (i_in_byte == r_end_char) begin
                o_q_cmd.is_end = 1'b1;
                n_capturing    = 1'b0;
                n_len          = '0;
                n_busy         = 1'b1;
            end else if (r_len >= LEN_W'(MAX_COMMAND)) begin
                n_capturing = 1'b0;
                n_len       = '0;
            end else begin
                store_we = 1'b1;
                n_len    = r_len + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_RESET;
            r_end_char   <= END_RESET;
            r_capturing  <= 1'b0;
            r_len        <= '0;
            r_busy       <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == REG_START_CHAR)) begin
                r_start_char <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_addr == REG_END_CHAR)) begin
                r_end_char <= i_cfg_data;
            end
            r_capturing <= n_capturing;
            r_len       <= n_len;
            r_busy      <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_len[ADDR_W-1:0]] <= i_in_byte;
        end
        r_rd_data <= r_store[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/dcd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dcd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dcd_pkg::t_cmd o_cmd
);
    import dcd_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/dcd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer back end
// Executes queued commands: emits echoes, reads out a finished command and
// appends the line ending, through a single output register.
// ----------------------------------------------------------------------------
module dcd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  dcd_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output dcd_pkg::t_back_req o_req,
    input  logic [7:0]         i_rd_data,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_out_kind,
    output logic               o_last
);
    import dcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_CR   = 4'b0100,
        S_LF   = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] n_idx;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    t_kind            r_out_kind;
    logic             r_out_last;
    logic             slot_free;
    logic             load;
    logic [7:0]       ld_byte;
    t_kind            ld_kind;
    logic             ld_last;
    logic             done;

    assign slot_free = ~r_out_valid | pop;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        o_q_pop = 1'b0;
        load    = 1'b0;
        ld_byte = i_q_cmd.data;
        ld_kind = KIND_ECHO;
        ld_last = 1'b1;
        done    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_q_pop = 1'b1;
                    load    = 1'b1;
                    ld_last = ~i_q_cmd.is_end;
                    if (i_q_cmd.is_end) begin
                        n_idx   = '0;
                        n_len   = i_q_cmd.len;
                        n_state = (i_q_cmd.len == '0) ? S_CR : S_CMD;
                    end
                end
            end
            S_CMD: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_byte = i_rd_data;
                    ld_kind = KIND_CMD;
                    ld_last = 1'b0;
                    n_idx   = r_idx + 1'b1;
                    if (n_idx == r_len) begin
                        n_state = S_CR;
                    end
                end
            end
            S_CR: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_byte = CHAR_CR;
                    ld_kind = KIND_EOL;
                    ld_last = 1'b0;
                    n_state = S_LF;
                end
            end
            S_LF: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_byte = CHAR_LF;
                    ld_kind = KIND_EOL;
                    ld_last = 1'b1;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req.frame_done = done;
    assign o_req.rd_addr    = (n_idx < LEN_W'(MAX_COMMAND)) ? n_idx[ADDR_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_len   <= n_len;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= ld_byte;
            r_out_kind <= ld_kind;
            r_out_last <= ld_last;
        end
    end

    assign empty      = ~r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_kind = r_out_kind;
    assign o_last     = r_out_last;

endmodule

// ===== hw/rtl/delimited_command_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited command deframer
// Echoes received bytes and, on the end character, replays the captured
// command followed by CR and LF.
// ----------------------------------------------------------------------------
// An accepted byte's echo passes through the command queue and the back
// end's output register before it reaches the result ports; ordinary bytes
// can be pushed every cycle while the two-entry command queue has room. A
// byte that closes a frame holds full high until the back end has loaded
// the LF into its output register, as the command is read out one byte at a
// time through the single output register and the one read port of the
// command store. Zero bytes are accepted and dropped.
module delimited_command_deframer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dcd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_in_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_out_byte,
    output logic [1:0]                     o_out_kind,
    output logic                           o_last
);
    import dcd_pkg::*;

    logic      q_full;
    logic      q_push;
    t_cmd      q_in;
    logic      q_pop;
    logic      q_valid;
    t_cmd      q_out;
    t_back_req back_req;
    logic [7:0] rd_data;

    dcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in),
        .i_req      (back_req),
        .o_rd_data  (rd_data)
    );

    dcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    dcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_req      (back_req),
        .i_rd_data  (rd_data),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_kind (o_out_kind),
        .o_last     (o_last)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("Command queue overrun.");

    a_cmd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_kind == KIND_CMD)) |-> !o_last)
        else $error("Command byte marked as last.");

    a_lf_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_kind == KIND_EOL) && (o_out_byte == CHAR_LF)) |-> o_last)
        else $error("Line feed not marked as last.");

    a_pop_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("Command queue underrun.");

endmodule

// ===== tb/sv/tb_delimited_command_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited command deframer testbench
// Feeds received bytes through a paced driver, predicts the echo, command and
// line ending replies of every accepted byte, and checks each popped reply.
// The start and end characters are reprogrammed between quiet phases.
// ----------------------------------------------------------------------------
module tb_delimited_command_deframer_unit;
    import dcd_pkg::*;

    localparam int unsigned ITEMS       = 460;
    localparam int unsigned QUIET       = 24;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL        = 100;
    localparam int unsigned LIMIT       = 1000000;

    typedef enum logic [1:0] {
        STEP_BYTE,
        STEP_WRITE,
        STEP_HOLD
    } t_step_kind;

    typedef struct {
        t_step_kind            kind;
        logic [7:0]            data;
        logic [CFG_ADDR_W-1:0] reg_idx;
        int unsigned           gap;
    } t_step;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_reply;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [7:0]            i_cfg_data = 8'h00;
    logic                  push       = 1'b0;
    logic                  full;
    logic [7:0]            i_in_byte  = 8'h00;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [7:0]            o_out_byte;
    logic [1:0]            o_out_kind;
    logic                  o_last;

    t_step       step_q[$];
    t_reply      reply_q[$];

    // Tracked deframer state and programmed delimiters.
    logic        trk_capturing;
    logic [7:0]  trk_store[MAX_COMMAND];
    int unsigned trk_len;
    logic [7:0]  trk_start;
    logic [7:0]  trk_end;

    logic [7:0]  gen_start;
    logic [7:0]  gen_end;
    logic        gen_burst;
    int unsigned gen_items;

    int unsigned gap_cnt;
    int unsigned quiet_cnt;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_cnt;
    int unsigned rx_wait;
    logic        rx_burst;
    int unsigned err_cnt;
    int unsigned cycle_cnt;

    delimited_command_deframer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_kind (o_out_kind),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic predict_reply(input logic [7:0] b);
        int unsigned k;
        if (b == 8'h00) begin
            return;
        end
        if (!trk_capturing) begin
            reply_q.push_back('{b, KIND_ECHO, 1'b1});
            if (b == trk_start) begin
                trk_capturing = 1'b1;
                trk_len       = 0;
            end
        end else if (b == trk_start) begin
            reply_q.push_back('{b, KIND_ECHO, 1'b1});
            trk_len = 0;
        end else if (b == trk_end) begin
            reply_q.push_back('{b, KIND_ECHO, 1'b0});
            for (k = 0; k < trk_len; k++) begin
                reply_q.push_back('{trk_store[k], KIND_CMD, 1'b0});
            end
            reply_q.push_back('{CHAR_CR, KIND_EOL, 1'b0});
            reply_q.push_back('{CHAR_LF, KIND_EOL, 1'b1});
            trk_capturing = 1'b0;
            trk_len       = 0;
        end else begin
            reply_q.push_back('{b, KIND_ECHO, 1'b1});
            if (trk_len >= MAX_COMMAND) begin
                trk_capturing = 1'b0;
                trk_len       = 0;
            end else begin
                trk_store[trk_len] = b;
                trk_len++;
            end
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        int unsigned g;
        g = gen_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 15) == 0) begin
            gen_burst = !gen_burst;
        end
        step_q.push_back('{STEP_BYTE, b, '0, g});
        if (b != 8'h00) begin
            gen_items++;
        end
    endtask

    task automatic add_delims(input logic [7:0] s, input logic [7:0] e);
        step_q.push_back('{STEP_WRITE, s, REG_START_CHAR, 0});
        step_q.push_back('{STEP_WRITE, e, REG_END_CHAR, 0});
        gen_start = s;
        gen_end   = e;
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == gen_start || b == gen_end);
        return b;
    endfunction

    task automatic add_frame(input int unsigned len, input logic closed);
        add_byte(gen_start);
        repeat (len) add_byte(body_byte());
        if (closed) begin
            add_byte(gen_end);
        end
    endtask

    task automatic add_traffic(input int unsigned n);
        int unsigned target;
        int unsigned r;
        target = gen_items + n;
        while (gen_items < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        add_frame(MAX_COMMAND, 1'b1);
                    end else if (r == 1) begin
                        add_frame($urandom_range(MAX_COMMAND + 1, MAX_COMMAND + 3), 1'b1);
                    end else begin
                        add_frame($urandom_range(0, 12), 1'b1);
                    end
                end
                6, 7: begin
                    repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
                end
                8: begin
                    add_frame($urandom_range(0, 6), 1'b0);
                end
                default: begin
                    add_byte($urandom_range(0, 1) ? gen_end : 8'h00);
                end
            endcase
        end
    endtask

    initial begin
        int unsigned ph;
        gen_start = START_RESET;
        gen_end   = END_RESET;
        gen_burst = 1'b0;
        gen_items = 0;

        // Zero bytes, extremes, an end while hunting, restarts, short frames, a full-length and an overlong frame.
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(END_RESET);
        add_byte(START_RESET);
        add_byte(8'h01);
        add_byte(8'h80);
        add_byte(START_RESET);
        add_byte(8'h7F);
        add_byte(8'h00);
        add_byte(8'hFE);
        add_byte(END_RESET);
        add_byte(START_RESET);
        add_byte(END_RESET);
        add_byte(8'h55);
        add_byte(8'hAA);
        add_frame(MAX_COMMAND, 1'b1);
        add_frame(MAX_COMMAND + 1, 1'b1);

        for (ph = 0; gen_items < ITEMS; ph++) begin
            case (ph)
                0: add_delims(START_RESET, END_RESET);
                1: add_delims(8'hFF, 8'h01);
                2: add_delims(8'h00, 8'hFF);
                3: add_delims(8'h7E, 8'h7E);
                4: add_delims(8'h01, 8'h00);
                default: add_delims(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            endcase
            if (ph == 1) begin
                step_q.push_back('{STEP_HOLD, 8'h00, '0, 0});
                gen_burst = 1'b1;
                repeat (4) add_frame($urandom_range(2, 10), 1'b1);
            end
            add_traffic(60);
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (step_q.size() != 0 || push || reply_q.size() != 0);
        repeat (TAIL) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("%0t: timeout with %0d replies outstanding", $time, reply_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive_proc
        logic push_nx;
        logic we_nx;
        if (!i_rst_n) begin
            push          <= 1'b0;
            i_cfg_we      <= 1'b0;
            trk_capturing  = 1'b0;
            trk_len        = 0;
            trk_start      = START_RESET;
            trk_end        = END_RESET;
            gap_cnt        = 0;
            quiet_cnt      = 0;
            hold_req       = 0;
        end else if (!(push && full)) begin
            push_nx = 1'b0;
            we_nx   = 1'b0;
            if (push) begin
                predict_reply(i_in_byte);
            end
            if (reply_q.size() != 0) begin
                quiet_cnt = 0;
            end else if (quiet_cnt < QUIET) begin
                quiet_cnt++;
            end
            if (step_q.size() != 0) begin
                case (step_q[0].kind)
                    STEP_BYTE: begin
                        if (gap_cnt < step_q[0].gap) begin
                            gap_cnt++;
                        end else begin
                            push_nx    = 1'b1;
                            i_in_byte <= step_q[0].data;
                            gap_cnt    = 0;
                            void'(step_q.pop_front());
                        end
                    end
                    STEP_WRITE: begin
                        if (quiet_cnt == QUIET) begin
                            we_nx       = 1'b1;
                            i_cfg_addr <= step_q[0].reg_idx;
                            i_cfg_data <= step_q[0].data;
                            if (step_q[0].reg_idx == REG_START_CHAR) begin
                                trk_start = step_q[0].data;
                            end else begin
                                trk_end = step_q[0].data;
                            end
                            quiet_cnt = 0;
                            void'(step_q.pop_front());
                        end
                    end
                    default: begin
                        hold_req++;
                        void'(step_q.pop_front());
                    end
                endcase
            end
            push     <= push_nx;
            i_cfg_we <= we_nx;
        end
    end

    always @(posedge i_clk) begin : watch_proc
        logic   pop_nx;
        t_reply want;
        if (!i_rst_n) begin
            pop      <= 1'b0;
            hold_seen = 0;
            hold_cnt  = 0;
            rx_wait   = 0;
            rx_burst  = 1'b0;
            err_cnt   = 0;
        end else begin
            pop_nx = pop;
            if (pop && !empty) begin
                if (reply_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: expected no transaction, got byte %02h kind %0d last %0b",
                             $time, o_out_byte, o_out_kind, o_last);
                end else begin
                    want = reply_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        err_cnt++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.data, o_out_byte);
                    end
                    if (o_out_kind !== want.kind) begin
                        err_cnt++;
                        $display("%0t: out_kind expected %0d, got %0d",
                                 $time, want.kind, o_out_kind);
                    end
                    if (o_last !== want.last) begin
                        err_cnt++;
                        $display("%0t: last expected %0b, got %0b", $time, want.last, o_last);
                    end
                end
                pop_nx  = 1'b0;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
                if ($urandom_range(0, 31) == 0) begin
                    rx_burst = !rx_burst;
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                pop_nx = 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_cnt  = HOLD_CYCLES;
                pop_nx    = 1'b0;
            end else if (!pop_nx) begin
                if (rx_wait != 0) begin
                    rx_wait--;
                end else begin
                    pop_nx = 1'b1;
                end
            end
            pop <= pop_nx;
        end
    end

endmodule
